@@ src/bmg_pkg.sv @@
`timescale 1ns / 1ps
// bmg_pkg: shared types, sizes and codes of the mixture cell update core
// depends on nothing

package bmg_pkg;

    localparam int ROWS           = 64;
    localparam int COLUMNS        = 256;
    localparam int MAX_COMPONENTS = 16;

    localparam int ROW_W      = 6;
    localparam int COL_W      = 8;
    localparam int COMP_W     = 4;
    localparam int PRIOR_W    = 16;
    localparam int CIU_W      = 5;
    localparam int U_W        = 32;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int K_W  = $clog2(MAX_COMPONENTS);
    localparam int KK_W = $clog2(MAX_COMPONENTS + 1);

    localparam int CELL_AW    = ROW_W + COL_W;
    localparam int COLC_AW    = COL_W + K_W;
    localparam int ROWC_AW    = ROW_W + K_W;
    localparam int CELL_DEPTH = 1 << CELL_AW;
    localparam int COLC_DEPTH = 1 << COLC_AW;
    localparam int ROWC_DEPTH = 1 << ROWC_AW;
    localparam int CLR_DEPTH_A = (CELL_DEPTH > COLC_DEPTH) ? CELL_DEPTH : COLC_DEPTH;
    localparam int CLR_DEPTH   = (CLR_DEPTH_A > ROWC_DEPTH) ? CLR_DEPTH_A : ROWC_DEPTH;
    localparam int CLR_AW      = $clog2(CLR_DEPTH);

    localparam int CNT_W = $clog2(ROWS + 1);
    localparam int RT_W  = $clog2(COLUMNS + 1);

    localparam int FRAC_SHIFT = 8;
    localparam int G_W = ((RT_W + FRAC_SHIFT > PRIOR_W) ? RT_W + FRAC_SHIFT : PRIOR_W) + 1;
    localparam int H_W = ((CNT_W + FRAC_SHIFT > PRIOR_W) ? CNT_W + FRAC_SHIFT : PRIOR_W) + 1;
    localparam int D_W = ((CNT_W + FRAC_SHIFT + 1 > PRIOR_W + 1) ?
                          CNT_W + FRAC_SHIFT + 1 : PRIOR_W + 1) + 1;
    localparam int P_W = G_W + H_W;
    localparam int N_W = P_W + FRAC_SHIFT;
    localparam int T_W = N_W + K_W;
    localparam int UCNT_W = $clog2(U_W);

    localparam logic ACT_LOAD     = 1'b0;
    localparam logic ACT_RESAMPLE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SKIPPED  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BETA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAMMA = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CIU   = 2'd3;

    localparam logic [PRIOR_W-1:0] PRIOR_RESET = 16'd256;
    localparam logic [CIU_W-1:0]   CIU_RESET   = 5'd16;

    typedef struct packed {
        logic              action;
        logic [ROW_W-1:0]  row_index;
        logic [COL_W-1:0]  column_index;
        logic              cell_bit;
        logic              cell_present;
        logic [COMP_W-1:0] load_component;
        logic [U_W-1:0]    random_uniform;
    } bmg_in_t;

    typedef struct packed {
        logic [COMP_W-1:0]   chosen_component;
        logic [COMP_W-1:0]   previous_component;
        logic [STATUS_W-1:0] status;
    } bmg_out_t;

    typedef struct packed {
        logic [COMP_W-1:0] comp;
        logic              data_bit;
        logic              observed;
    } cell_t;

    function automatic logic [KK_W-1:0] effective_k(input logic [CIU_W-1:0] ciu);
        int unsigned v;
        v = ciu;
        if (v < 1) v = 1;
        if (v > MAX_COMPONENTS) v = MAX_COMPONENTS;
        return KK_W'(v);
    endfunction

endpackage

@@ src/bmg_divider.sv @@
`timescale 1ns / 1ps
// bmg_divider: restoring divider, one quotient bit per cycle
// depends on bmg_pkg

module bmg_divider (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [bmg_pkg::N_W-1:0] numerator,
    input  logic [bmg_pkg::D_W-1:0] denominator,
    output logic                    done,
    output logic [bmg_pkg::N_W-1:0] quotient
);
    import bmg_pkg::*;

    localparam int STEP_W = $clog2(N_W);

    logic              active_reg, active_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [N_W-1:0]    shift_reg, shift_next;
    logic [D_W-1:0]    rem_reg, rem_next;
    logic [D_W-1:0]    den_reg, den_next;
    logic [D_W:0]      trial;
    logic [D_W:0]      diff;
    logic              fits;

    assign trial = {rem_reg, shift_reg[N_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        step_next   = step_reg;
        shift_next  = shift_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        if (start)
        begin
            active_next = 1'b1;
            step_next   = '0;
            shift_next  = numerator;
            rem_next    = '0;
            den_next    = denominator;
        end
        else if (active_reg)
        begin
            rem_next   = fits ? diff[D_W-1:0] : trial[D_W-1:0];
            shift_next = {shift_reg[N_W-2:0], fits};
            step_next  = step_reg + 1'b1;
            if (step_reg == STEP_W'(N_W - 1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
    end

    assign done     = done_reg;
    assign quotient = shift_reg;

endmodule

@@ src/bernoulli_mixture_gibbs_cell_update_core.sv @@
`timescale 1ns / 1ps
// bernoulli_mixture_gibbs_cell_update_core: collapsed gibbs update of one matrix cell
// depends on bmg_pkg and bmg_divider
//
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall  | in_item (bmg_in_t)
// out     | output    | out_valid / out_stall| out_item (bmg_out_t)
// cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// after reset a clearing pass over the 16384-entry cell store and the count stores runs before the first transaction
// load: updates the cell and its counts; resample of an observed cell: computes one weight per
// component in use with the shared bit-serial divider, then draws a target and selects a component
// one item is in work at a time
// a stalled result is held in the output register while the next item is taken

module bernoulli_mixture_gibbs_cell_update_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  bmg_pkg::bmg_in_t               in_item,
    output logic                           out_valid,
    input  logic                           out_stall,
    output bmg_pkg::bmg_out_t              out_item,
    input  logic                           cfg_we,
    input  logic [bmg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bmg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bmg_pkg::*;

    typedef enum logic [13:0] {
        S_CLEAR  = 14'b00000000000001,
        S_IDLE   = 14'b00000000000010,
        S_CELL   = 14'b00000000000100,
        S_REM_RD = 14'b00000000001000,
        S_REM_WR = 14'b00000000010000,
        S_ADD_RD = 14'b00000000100000,
        S_ADD_WR = 14'b00000001000000,
        S_W_RD   = 14'b00000010000000,
        S_W_MUL  = 14'b00000100000000,
        S_W_GO   = 14'b00001000000000,
        S_W_DIV  = 14'b00010000000000,
        S_TGT    = 14'b00100000000000,
        S_SEL    = 14'b01000000000000,
        S_DONE   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [PRIOR_W-1:0] alpha_reg, beta_reg, gamma_reg;
    logic [CIU_W-1:0]   ciu_reg;
    logic [KK_W-1:0]    kk;

    bmg_in_t             item_reg, item_next;
    logic [K_W-1:0]      prev_reg, prev_next;
    logic [K_W-1:0]      chosen_reg, chosen_next;
    logic                obit_reg, obit_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [KK_W-1:0]     k_reg, k_next;
    logic [T_W-1:0]      total_reg, total_next;
    logic [T_W-1:0]      cum_reg, cum_next;
    logic [T_W-1:0]      acc_reg, acc_next;
    logic [U_W-1:0]      u_reg, u_next;
    logic [UCNT_W-1:0]   ucnt_reg, ucnt_next;
    logic [P_W-1:0]      prod_reg, prod_next;
    logic [D_W-1:0]      den_reg, den_next;
    logic [CLR_AW-1:0]   clr_reg, clr_next;
    logic [N_W-1:0]      w_reg [MAX_COMPONENTS];
    logic                w_we;
    logic [N_W-1:0]      w_val;

    logic     out_valid_reg, out_valid_next;
    bmg_out_t out_item_reg, out_item_next;

    // cell and count stores
    cell_t            cell_mem [CELL_DEPTH];
    logic [CNT_W-1:0] ones_mem [COLC_DEPTH];
    logic [CNT_W-1:0] zeros_mem [COLC_DEPTH];
    logic [RT_W-1:0]  row_mem [ROWC_DEPTH];

    cell_t            cell_rd_reg, cell_wdata;
    logic [CNT_W-1:0] ones_rd_reg, zeros_rd_reg, ones_wdata, zeros_wdata;
    logic [RT_W-1:0]  row_rd_reg, row_wdata;
    logic             cell_we, ones_we, zeros_we, row_we;
    logic [CELL_AW-1:0] cell_raddr, cell_waddr;
    logic [COLC_AW-1:0] col_addr;
    logic [ROWC_AW-1:0] row_addr;
    logic [K_W-1:0]     kidx;
    logic               upd_bit, is_upd, is_add, clearing;
    logic               clr_cell, clr_col, clr_row, reject;

    logic [G_W-1:0] g_val;
    logic [H_W-1:0] h_val;
    logic [D_W-1:0] d_val;
    logic [T_W:0]   tgt_sum;
    logic [T_W-1:0] sel_sum;

    logic           div_start, div_done;
    logic [N_W-1:0] div_q;

    bmg_divider u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .numerator  ({prod_reg, FRAC_SHIFT'(0)}),
        .denominator(den_reg),
        .done       (div_done),
        .quotient   (div_q)
    );

    assign kk        = effective_k(ciu_reg);
    assign div_start = (state_reg == S_W_GO);
    assign clearing  = (state_reg == S_CLEAR);
    assign clr_cell  = ({1'b0, clr_reg} < (CLR_AW + 1)'(CELL_DEPTH));
    assign clr_col   = ({1'b0, clr_reg} < (CLR_AW + 1)'(COLC_DEPTH));
    assign clr_row   = ({1'b0, clr_reg} < (CLR_AW + 1)'(ROWC_DEPTH));
    assign reject    = (KK_W'(item_reg.load_component) >= kk);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= PRIOR_RESET;
            beta_reg  <= PRIOR_RESET;
            gamma_reg <= PRIOR_RESET;
            ciu_reg   <= CIU_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ALPHA: alpha_reg <= cfg_data[PRIOR_W-1:0];
                REG_BETA:  beta_reg  <= cfg_data[PRIOR_W-1:0];
                REG_GAMMA: gamma_reg <= cfg_data[PRIOR_W-1:0];
                REG_CIU:   ciu_reg   <= cfg_data[CIU_W-1:0];
                default:   ciu_reg   <= ciu_reg;
            endcase
        end
    end

    // store addressing and read-modify-write of counts
    always_comb
    begin
        case (state_reg)
            S_REM_RD, S_REM_WR: kidx = prev_reg;
            S_ADD_RD, S_ADD_WR: kidx = chosen_reg;
            default:            kidx = k_reg[K_W-1:0];
        endcase
        is_add  = (state_reg == S_ADD_WR);
        is_upd  = (state_reg == S_REM_WR) || is_add;
        upd_bit = ((state_reg == S_ADD_WR) && (item_reg.action == ACT_LOAD)) ?
                  item_reg.cell_bit : obit_reg;

        cell_raddr = {in_item.row_index, in_item.column_index};
        if (clearing)
        begin
            cell_waddr = clr_reg[CELL_AW-1:0];
            col_addr   = clr_reg[COLC_AW-1:0];
            row_addr   = clr_reg[ROWC_AW-1:0];
        end
        else
        begin
            cell_waddr = {item_reg.row_index, item_reg.column_index};
            col_addr   = {item_reg.column_index, kidx};
            row_addr   = {item_reg.row_index, kidx};
        end

        cell_wdata = '0;
        cell_we    = clearing && clr_cell;
        if ((state_reg == S_CELL) && (item_reg.action == ACT_LOAD) && !reject)
        begin
            cell_we    = 1'b1;
            cell_wdata = '{comp: item_reg.load_component, data_bit: item_reg.cell_bit,
                           observed: item_reg.cell_present};
        end
        else if (is_add && (item_reg.action == ACT_RESAMPLE))
        begin
            cell_we    = 1'b1;
            cell_wdata = '{comp: chosen_reg, data_bit: obit_reg, observed: 1'b1};
        end

        if (clearing)
        begin
            ones_wdata  = '0;
            zeros_wdata = '0;
            row_wdata   = '0;
        end
        else if (is_add)
        begin
            ones_wdata  = ones_rd_reg + 1'b1;
            zeros_wdata = zeros_rd_reg + 1'b1;
            row_wdata   = row_rd_reg + 1'b1;
        end
        else
        begin
            ones_wdata  = (ones_rd_reg == '0) ? '0 : ones_rd_reg - 1'b1;
            zeros_wdata = (zeros_rd_reg == '0) ? '0 : zeros_rd_reg - 1'b1;
            row_wdata   = (row_rd_reg == '0) ? '0 : row_rd_reg - 1'b1;
        end
        ones_we  = (clearing && clr_col) || (is_upd && upd_bit);
        zeros_we = (clearing && clr_col) || (is_upd && !upd_bit);
        row_we   = (clearing && clr_row) || is_upd;
    end

    always_ff @(posedge clk)
    begin
        if (cell_we)
            cell_mem[cell_waddr] <= cell_wdata;
        cell_rd_reg <= cell_mem[cell_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ones_we)
            ones_mem[col_addr] <= ones_wdata;
        ones_rd_reg <= ones_mem[col_addr];
    end

    always_ff @(posedge clk)
    begin
        if (zeros_we)
            zeros_mem[col_addr] <= zeros_wdata;
        zeros_rd_reg <= zeros_mem[col_addr];
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
            row_mem[row_addr] <= row_wdata;
        row_rd_reg <= row_mem[row_addr];
    end

    // weight operands
    always_comb
    begin
        g_val = G_W'(gamma_reg) + (G_W'(row_rd_reg) << FRAC_SHIFT);
        if (obit_reg)
            h_val = H_W'(alpha_reg) + (H_W'(ones_rd_reg) << FRAC_SHIFT);
        else
            h_val = H_W'(beta_reg) + (H_W'(zeros_rd_reg) << FRAC_SHIFT);
        d_val = D_W'(alpha_reg) + D_W'(beta_reg) +
                ((D_W'(ones_rd_reg) + D_W'(zeros_rd_reg)) << FRAC_SHIFT);
        tgt_sum = {1'b0, acc_reg} + (u_reg[0] ? {1'b0, total_reg} : '0);
        sel_sum = cum_reg + T_W'(w_reg[k_reg[K_W-1:0]]);
        w_val   = (den_reg == '0) ? '0 : div_q;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        prev_next      = prev_reg;
        chosen_next    = chosen_reg;
        obit_next      = obit_reg;
        status_next    = status_reg;
        k_next         = k_reg;
        total_next     = total_reg;
        cum_next       = cum_reg;
        acc_next       = acc_reg;
        u_next         = u_reg;
        ucnt_next      = ucnt_reg;
        prod_next      = prod_reg;
        den_next       = den_reg;
        clr_next       = clr_reg;
        w_we           = 1'b0;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_AW'(CLR_DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_item;
                    state_next = S_CELL;
                end
            end
            S_CELL:
            begin
                prev_next   = cell_rd_reg.comp;
                chosen_next = cell_rd_reg.comp;
                obit_next   = cell_rd_reg.data_bit;
                status_next = STATUS_DONE;
                if (item_reg.action == ACT_LOAD)
                begin
                    if (reject)
                    begin
                        status_next = STATUS_REJECTED;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        chosen_next = item_reg.load_component;
                        if (cell_rd_reg.observed)
                            state_next = S_REM_RD;
                        else if (item_reg.cell_present)
                            state_next = S_ADD_RD;
                        else
                            state_next = S_DONE;
                    end
                end
                else if (!cell_rd_reg.observed)
                begin
                    status_next = STATUS_SKIPPED;
                    state_next  = S_DONE;
                end
                else
                    state_next = S_REM_RD;
            end
            S_REM_RD:
                state_next = S_REM_WR;
            S_REM_WR:
            begin
                if (item_reg.action == ACT_LOAD)
                    state_next = item_reg.cell_present ? S_ADD_RD : S_DONE;
                else
                begin
                    k_next     = '0;
                    total_next = '0;
                    state_next = S_W_RD;
                end
            end
            S_ADD_RD:
                state_next = S_ADD_WR;
            S_ADD_WR:
                state_next = S_DONE;
            S_W_RD:
                state_next = S_W_MUL;
            S_W_MUL:
            begin
                prod_next  = g_val * h_val;
                den_next   = d_val;
                state_next = S_W_GO;
            end
            S_W_GO:
                state_next = S_W_DIV;
            S_W_DIV:
            begin
                if (div_done)
                begin
                    w_we       = 1'b1;
                    total_next = total_reg + T_W'(w_val);
                    if (k_reg + 1'b1 == kk)
                    begin
                        acc_next   = '0;
                        u_next     = item_reg.random_uniform;
                        ucnt_next  = '0;
                        state_next = S_TGT;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_W_RD;
                    end
                end
            end
            S_TGT:
            begin
                acc_next  = tgt_sum[T_W:1];
                u_next    = u_reg >> 1;
                ucnt_next = ucnt_reg + 1'b1;
                if (ucnt_reg == UCNT_W'(U_W - 1))
                begin
                    k_next     = '0;
                    cum_next   = '0;
                    state_next = S_SEL;
                end
            end
            S_SEL:
            begin
                cum_next = sel_sum;
                k_next   = k_reg + 1'b1;
                if (sel_sum > acc_reg)
                begin
                    chosen_next = k_reg[K_W-1:0];
                    state_next  = S_ADD_RD;
                end
                else if (k_reg + 1'b1 == kk)
                begin
                    chosen_next = '0;
                    state_next  = S_ADD_RD;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = '{chosen_component: chosen_reg,
                                       previous_component: prev_reg,
                                       status: status_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        prev_reg     <= prev_next;
        chosen_reg   <= chosen_next;
        obit_reg     <= obit_next;
        status_reg   <= status_next;
        k_reg        <= k_next;
        total_reg    <= total_next;
        cum_reg      <= cum_next;
        acc_reg      <= acc_next;
        u_reg        <= u_next;
        ucnt_reg     <= ucnt_next;
        prod_reg     <= prod_next;
        den_reg      <= den_next;
        out_item_reg <= out_item_next;
        if (w_we)
            w_reg[k_reg[K_W-1:0]] <= w_val;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

@@ src/bmg_checker.sv @@
`timescale 1ns / 1ps
// bmg_checker: port-level checks of the mixture cell update core
// depends on bmg_pkg; bound to bernoulli_mixture_gibbs_cell_update_core

module bmg_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input bmg_pkg::bmg_out_t out_item
);
    import bmg_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while an item is in work");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.status == STATUS_DONE) ||
                      (out_item.status == STATUS_SKIPPED) ||
                      (out_item.status == STATUS_REJECTED))
        else $error("undefined status code");

    // skipped or rejected items leave the assignment as it was
    a_unchanged: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((out_item.status == STATUS_SKIPPED) ||
                      (out_item.status == STATUS_REJECTED))
        |-> out_item.chosen_component == out_item.previous_component)
        else $error("assignment changed on skipped or rejected item");

endmodule

bind bernoulli_mixture_gibbs_cell_update_core bmg_checker u_bmg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
);
